// ===== design/feedback_delay_echo_top_defines.svh =====
// Assertion macros shared by the echo block.
// Both sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef FEEDBACK_DELAY_ECHO_TOP_DEFINES_SVH
`define FEEDBACK_DELAY_ECHO_TOP_DEFINES_SVH

// Same-cycle implication.
`define FDE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FDE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fde_pkg.sv =====
`timescale 1ns / 1ps

package fde_pkg;

	localparam int DELAY_W         = 15;
	localparam int GAIN_W          = 17;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = 17;
	localparam int STORE_DEPTH_DEF = 32768;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int ROUND_HALF      = 32768;
	localparam int ROUND_SHIFT     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIX      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 4'd3;

	localparam logic [DELAY_W-1:0] DELAY_RST  = 15'd12000;
	localparam logic [GAIN_W-1:0]  FB_RST     = 17'd32768;
	localparam logic [GAIN_W-1:0]  MIX_RST    = 17'd32768;
	localparam logic [GAIN_W-1:0]  GAIN_ONE   = 17'h10000;
	localparam logic               ENABLE_RST = 1'b1;

	typedef struct packed {
		logic              enable;
		logic              delay_zero;
		logic [GAIN_W-1:0] fb_gain;
		logic [GAIN_W-1:0] mix_gain;
	} cfg_t;

	function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
		return g[GAIN_W-1] ? GAIN_ONE : g;
	endfunction

endpackage

// ===== design/feedback_delay_echo_top.sv =====
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+----------------------------------
// in      | in        | in_valid / in_stall   | sample_in
// out     | out       | out_valid / out_stall | sample_out
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low; a result moves from
// stage one (loaded at the accept) to stage two, then to the output register, the echo
// store being a dual-port RAM.
// Reset clears control state and loads configuration defaults; unwritten store
// entries read as zero through a wrap flag, so there is no clearing pass.
// While out_stall holds the output register, up to two more transactions fill the
// stages, then in_stall rises.
`timescale 1ns / 1ps
`include "feedback_delay_echo_top_defines.svh"

module feedback_delay_echo_top #(
	parameter int STORE_DEPTH = fde_pkg::STORE_DEPTH_DEF,
	parameter int SAMPLE_BITS = fde_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       sample_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       sample_out,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fde_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fde_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import fde_pkg::*;

	localparam int AW  = $clog2(STORE_DEPTH);
	localparam int SB  = SAMPLE_BITS;
	localparam int PFW = SB + GAIN_W + 1;
	localparam int PMW = SB + GAIN_W + 2;

	cfg_t               cfg;
	logic [DELAY_W-1:0] delay_mod;
	logic [AW-1:0]      wp_next;
	logic [AW-1:0]      rd_next;
	logic               written_next;
	logic signed [SB-1:0] ram_rdata;

	logic in_fire;
	logic en_out;
	logic en_s2;
	logic en_s1;
	logic wr_en;

	logic                 vld_s1;
	logic signed [SB-1:0] x_s1;
	logic [AW-1:0]        rd_s1;
	logic [AW-1:0]        wp_s1;
	logic                 written_s1;
	logic                 hit_s1;
	logic signed [SB-1:0] fwd_s1;

	logic                  vld_s2;
	logic signed [SB-1:0]  x_s2;
	logic signed [SB-1:0]  wet_s2;
	logic signed [PMW-1:0] pmix_s2;
	logic [AW-1:0]         wp_s2;

	logic                 out_vld_q;
	logic signed [SB-1:0] sample_q;

	logic signed [SB-1:0]   delayed;
	logic signed [PFW-1:0]  pfb;
	logic signed [PFW-1:0]  pfb_r;
	logic signed [SB+1:0]   fb_rnd;
	logic signed [SB+2:0]   wet_sum;
	logic signed [SB-1:0]   wet;
	logic signed [SB:0]     diff;
	logic signed [PMW-1:0]  pmix;
	logic signed [PMW-1:0]  pmix_r;
	logic signed [SB+2:0]   mix_rnd;
	logic signed [SB+3:0]   y_sum;
	logic signed [SB-1:0]   y;

	fde_cfg #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg),
		.delay_mod(delay_mod)
	);

	fde_addr #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (in_fire && cfg.enable),
		.delay_mod (delay_mod),
		.wp        (wp_next),
		.rd        (rd_next),
		.rd_written(written_next)
	);

	fde_ram #(
		.WIDTH(SB),
		.DEPTH(STORE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wp_s2),
		.wdata(wet_s2),
		.re   (in_fire),
		.raddr(rd_next),
		.rdata(ram_rdata)
	);

	assign cfg_ready  = 1'b1;
	assign en_out     = !out_vld_q || !out_stall;
	assign en_s2      = !vld_s2 || en_out;
	assign en_s1      = !vld_s1 || en_s2;
	assign in_stall   = !en_s1;
	assign in_fire    = in_valid && en_s1;
	assign wr_en      = vld_s2 && en_out && cfg.enable;
	assign out_valid  = out_vld_q;
	assign sample_out = sample_q;

	// input when off or delay zero, else newest of: stage two, write at accept, RAM, zero
	always_comb begin
		if (!cfg.enable || cfg.delay_zero) begin
			delayed = x_s1;
		end else if (vld_s2 && (wp_s2 == rd_s1)) begin
			delayed = wet_s2;
		end else if (hit_s1) begin
			delayed = fwd_s1;
		end else if (written_s1) begin
			delayed = ram_rdata;
		end else begin
			delayed = '0;
		end
	end

	assign pfb     = $signed({1'b0, cfg.fb_gain}) * delayed;
	assign pfb_r   = pfb + PFW'(ROUND_HALF);
	assign fb_rnd  = pfb_r[PFW-1:ROUND_SHIFT];
	assign wet_sum = (SB+3)'(x_s1) + (SB+3)'(fb_rnd);
	assign wet     = (wet_sum[SB+2:SB-1] != {4{wet_sum[SB+2]}}) ?
		{wet_sum[SB+2], {(SB-1){~wet_sum[SB+2]}}} : wet_sum[SB-1:0];

	assign diff    = (SB+1)'(delayed) - (SB+1)'(x_s1);
	assign pmix    = $signed({1'b0, cfg.mix_gain}) * diff;

	assign pmix_r  = pmix_s2 + PMW'(ROUND_HALF);
	assign mix_rnd = pmix_r[PMW-1:ROUND_SHIFT];
	assign y_sum   = (SB+4)'(x_s2) + (SB+4)'(mix_rnd);
	assign y       = (y_sum[SB+3:SB-1] != {5{y_sum[SB+3]}}) ?
		{y_sum[SB+3], {(SB-1){~y_sum[SB+3]}}} : y_sum[SB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= in_fire;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (en_out) begin
				out_vld_q <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_s1       <= sample_in;
			rd_s1      <= rd_next;
			wp_s1      <= wp_next;
			written_s1 <= written_next;
			// catch the write landing on the same edge as the read
			hit_s1     <= wr_en && (wp_s2 == rd_next);
			fwd_s1     <= wet_s2;
		end
		if (en_s2 && vld_s1) begin
			x_s2    <= x_s1;
			wet_s2  <= wet;
			pmix_s2 <= pmix;
			wp_s2   <= wp_s1;
		end
		if (en_out && vld_s2) begin
			sample_q <= y;
		end
	end

	`FDE_ASSERT_NOW(a_stall_only_when_full, in_stall, vld_s1 && vld_s2 && out_vld_q, "input stalled with a free stage")
	`FDE_ASSERT_NEXT(a_pointer_advances, in_fire && cfg.enable, wp_next != $past(wp_next), "write pointer did not advance")
	`FDE_ASSERT_NOW(a_out_from_stage, $rose(out_vld_q), $past(vld_s2), "result without a stage two transaction")

endmodule

// ===== design/fde_ram.sv =====
`timescale 1ns / 1ps

module fde_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32768,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/fde_cfg.sv =====
`timescale 1ns / 1ps

module fde_cfg #(
	parameter int STORE_DEPTH = fde_pkg::STORE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [fde_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fde_pkg::CFG_DATA_W-1:0]   cfg_data,
	output fde_pkg::cfg_t                    cfg,
	output logic [fde_pkg::DELAY_W-1:0]      delay_mod
);

	import fde_pkg::*;

	localparam int LOG_D   = $clog2(STORE_DEPTH);
	localparam int Q_SHIFT = DELAY_W + LOG_D;
	localparam int RECIP_W = DELAY_W + 2;
	localparam int PROD_W  = DELAY_W + RECIP_W;
	localparam longint RECIP_L =
		((longint'(1) << Q_SHIFT) + longint'(STORE_DEPTH) - 1) / longint'(STORE_DEPTH);
	localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_L);
	localparam logic [DELAY_W-1:0] QUOT_RST = DELAY_W'(int'(DELAY_RST) / STORE_DEPTH);

	logic [DELAY_W-1:0] delay_q;
	logic [DELAY_W-1:0] quot_q;
	logic [GAIN_W-1:0]  fb_q;
	logic [GAIN_W-1:0]  mix_q;
	logic               enable_q;
	logic [PROD_W-1:0]  prod;
	logic [DELAY_W-1:0] quot_d;
	logic [DELAY_W-1:0] mult_back;

	// quotient of the delay by the store depth, exact over the delay range
	assign prod      = PROD_W'(cfg_data[DELAY_W-1:0]) * PROD_W'(RECIP);
	assign quot_d    = DELAY_W'(prod >> Q_SHIFT);
	assign mult_back = DELAY_W'(quot_q * STORE_DEPTH);
	assign delay_mod = delay_q - mult_back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= DELAY_RST;
			quot_q   <= QUOT_RST;
			fb_q     <= FB_RST;
			mix_q    <= MIX_RST;
			enable_q <= ENABLE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DELAY: begin
					delay_q <= cfg_data[DELAY_W-1:0];
					quot_q  <= quot_d;
				end
				REG_FEEDBACK: begin
					fb_q <= cfg_data[GAIN_W-1:0];
				end
				REG_MIX: begin
					mix_q <= cfg_data[GAIN_W-1:0];
				end
				REG_ENABLE: begin
					enable_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.enable     = enable_q;
		cfg.delay_zero = (delay_q == '0);
		cfg.fb_gain    = clamp_gain(fb_q);
		cfg.mix_gain   = clamp_gain(mix_q);
	end

endmodule

// ===== design/fde_addr.sv =====
`timescale 1ns / 1ps

module fde_addr #(
	parameter int STORE_DEPTH = fde_pkg::STORE_DEPTH_DEF,
	localparam int AW = $clog2(STORE_DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [fde_pkg::DELAY_W-1:0] delay_mod,
	output logic [AW-1:0]               wp,
	output logic [AW-1:0]               rd,
	output logic                        rd_written
);

	import fde_pkg::*;

	localparam int XW = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
	localparam logic [XW-1:0] DEPTH_X = XW'(STORE_DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(STORE_DEPTH - 1);

	logic [AW-1:0] wp_q;
	logic          wrapped_q;
	logic [XW-1:0] sum;
	logic [XW-1:0] sum_adj;

	assign sum        = XW'(wp_q) + DEPTH_X - XW'(delay_mod);
	assign sum_adj    = (sum >= DEPTH_X) ? sum - DEPTH_X : sum;
	assign rd         = sum_adj[AW-1:0];
	assign wp         = wp_q;
	// entries behind the pointer hold data once written; before the first wrap the rest read as zero
	assign rd_written = wrapped_q || (rd < wp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (adv) begin
			if (wp_q == LAST) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

endmodule

// ===== tb/sv/tb_feedback_delay_echo_top.sv =====
`timescale 1ns / 1ps

module tb_feedback_delay_echo_top;
	import fde_pkg::*;

	localparam int SB    = SAMPLE_BITS_DEF;
	localparam int DEPTH = STORE_DEPTH_DEF;
	localparam longint LIM_HI = (longint'(1) << (SB - 1)) - 1;
	localparam longint LIM_LO = -LIM_HI - 1;
	localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB - 1){1'b1}}};
	localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB - 1){1'b0}}};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic signed [SB-1:0]   sample_in = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [SB-1:0]   sample_out;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic signed [SB-1:0]   echo_mem [DEPTH];
	int                     echo_wp;
	logic [DELAY_W-1:0]     cfg_delay;
	logic [GAIN_W-1:0]      cfg_fb;
	logic [GAIN_W-1:0]      cfg_mix;
	logic                   cfg_en;

	logic signed [SB-1:0]   expected_out [$];
	int                     errors = 0;
	bit                     idle_on = 1'b1;
	int                     stall_left = 0;

	feedback_delay_echo_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic longint clip(input longint v);
		if (v > LIM_HI) return LIM_HI;
		if (v < LIM_LO) return LIM_LO;
		return v;
	endfunction

	function automatic longint round_gain(input longint v);
		return (v + ROUND_HALF) >>> ROUND_SHIFT;
	endfunction

	function automatic logic signed [SB-1:0] predict_echo(input logic signed [SB-1:0] x);
		longint xv;
		longint dly;
		longint wet;
		longint mixv;
		logic [GAIN_W-1:0] fb;
		logic [GAIN_W-1:0] lvl;
		int rd;
		if (!cfg_en) return x;
		fb  = (cfg_fb > GAIN_ONE) ? GAIN_ONE : cfg_fb;
		lvl = (cfg_mix > GAIN_ONE) ? GAIN_ONE : cfg_mix;
		xv = x;
		if (cfg_delay == 0) begin
			dly = xv;
		end else begin
			rd = (echo_wp + DEPTH - int'(cfg_delay)) % DEPTH;
			dly = echo_mem[rd];
		end
		wet = clip(xv + round_gain(longint'(fb) * dly));
		echo_mem[echo_wp] = wet[SB-1:0];
		echo_wp = (echo_wp + 1) % DEPTH;
		mixv = clip(round_gain(longint'(lvl) * dly + longint'(GAIN_ONE - lvl) * xv));
		return mixv[SB-1:0];
	endfunction

	function automatic logic signed [SB-1:0] rand_sample();
		logic signed [SB-1:0] r;
		case ($urandom_range(0, 5))
			0: r = S_MAX;
			1: r = S_MIN;
			2: r = SB'(int'($urandom_range(0, 2000)) - 1000);
			default: r = SB'($urandom());
		endcase
		return r;
	endfunction

	function automatic int rand_gain();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return int'(GAIN_ONE);
			2: return $urandom_range(int'(GAIN_ONE) + 1, (1 << GAIN_W) - 1);
			default: return $urandom_range(0, int'(GAIN_ONE));
		endcase
	endfunction

	function automatic int rand_delay();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return (1 << DELAY_W) - 1;
			2: return $urandom_range(0, (1 << DELAY_W) - 1);
			default: return $urandom_range(1, 48);
		endcase
	endfunction

	// receiver stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 15) == 0) begin
			stall_left <= $urandom_range(1, 18) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		logic signed [SB-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected sample_out, expected none, actual %0d",
					$time, sample_out);
				errors++;
			end else begin
				want = expected_out.pop_front();
				if (sample_out !== want) begin
					$display("%0t: sample_out mismatch, expected %0d, actual %0d",
						$time, want, sample_out);
					errors++;
				end
			end
		end
	end

	task automatic send_sample(input logic signed [SB-1:0] x);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= x;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_out.push_back(predict_echo(x));
	endtask

	// hold off until every pending transaction has come out
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (expected_out.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DELAY:    cfg_delay = data[DELAY_W-1:0];
			REG_FEEDBACK: cfg_fb = data[GAIN_W-1:0];
			REG_MIX:      cfg_mix = data[GAIN_W-1:0];
			REG_ENABLE:   cfg_en = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input int d, input int fb, input int mix, input bit en);
		wait_quiet();
		cfg_write(REG_DELAY, CFG_DATA_W'(d));
		cfg_write(REG_FEEDBACK, CFG_DATA_W'(fb));
		cfg_write(REG_MIX, CFG_DATA_W'(mix));
		cfg_write(REG_ENABLE, CFG_DATA_W'(en));
	endtask

	task automatic test_reset_state();
		send_sample(S_MAX);
		send_sample(S_MIN);
		send_sample('0);
		send_sample('1);
	endtask

	task automatic test_feedback_saturation();
		configure(1, int'(GAIN_ONE), int'(GAIN_ONE), 1'b1);
		repeat (3) send_sample(S_MAX);
		repeat (3) send_sample(S_MIN);
	endtask

	task automatic test_gain_clamp();
		configure(2, (1 << GAIN_W) - 1, int'(GAIN_ONE) + 1, 1'b1);
		send_sample(S_MAX);
		send_sample(S_MIN);
		send_sample(rand_sample());
		configure(3, 0, 0, 1'b1);
		send_sample(S_MIN);
		send_sample(S_MAX);
	endtask

	task automatic test_zero_delay();
		configure(0, 40000, 20000, 1'b1);
		send_sample(S_MAX);
		send_sample(S_MIN);
		send_sample(rand_sample());
	endtask

	task automatic test_max_delay();
		configure((1 << DELAY_W) - 1, int'(GAIN_ONE), int'(GAIN_ONE), 1'b1);
		send_sample(S_MAX);
		send_sample(rand_sample());
	endtask

	task automatic test_bypass();
		configure(4, 50000, 30000, 1'b0);
		send_sample(S_MAX);
		send_sample(S_MIN);
		wait_quiet();
		cfg_write(REG_ENABLE, CFG_DATA_W'(1));
		send_sample(rand_sample());
		send_sample(rand_sample());
	endtask

	task automatic test_unused_index();
		wait_quiet();
		for (int i = int'(REG_ENABLE) + 1; i < (1 << CFG_IDX_W); i++)
			cfg_write(CFG_IDX_W'(i), CFG_DATA_W'($urandom()));
		repeat (4) send_sample(rand_sample());
	endtask

	task automatic test_random_stream();
		for (int ph = 0; ph < 10; ph++) begin
			configure(rand_delay() | ($urandom_range(0, 3) << DELAY_W), rand_gain(),
				rand_gain(), $urandom_range(0, 5) != 0);
			idle_on = ($urandom_range(0, 3) != 0);
			repeat (32) send_sample(rand_sample());
		end
	endtask

	// send a dense stream with no idling on either side
	task automatic test_dense_stream();
		idle_on = 1'b0;
		configure((1 << DELAY_W) - 1, rand_gain(), rand_gain(), 1'b1);
		repeat (24) send_sample(rand_sample());
		configure(5, rand_gain(), rand_gain(), 1'b1);
		repeat (24) send_sample(rand_sample());
	endtask

	initial begin
		foreach (echo_mem[i]) echo_mem[i] = '0;
		echo_wp = 0;
		cfg_delay = DELAY_RST;
		cfg_fb = FB_RST;
		cfg_mix = MIX_RST;
		cfg_en = ENABLE_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_state();
		test_feedback_saturation();
		test_gain_clamp();
		test_zero_delay();
		test_max_delay();
		test_bypass();
		test_unused_index();
		test_random_stream();
		test_dense_stream();
		wait_quiet();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/fde_pkg.sv
design/fde_ram.sv
design/fde_cfg.sv
design/fde_addr.sv
design/feedback_delay_echo_top.sv
tb/sv/tb_feedback_delay_echo_top.sv
